[hw/rtl/ppdt_pkg.sv]
// shared types and constants for the point projection and depth test block
`default_nettype none

package ppdt_pkg;

  localparam int unsigned FOCAL_W  = 31;
  localparam int unsigned CENTER_W = 10;
  localparam int unsigned PIX_W    = 10;
  localparam int unsigned COORD_W  = 32;
  localparam int unsigned DEPTH_W  = 32;
  localparam int unsigned FRAC_W   = 16;
  localparam int unsigned NUM_W    = 64;
  localparam int unsigned DEN_W    = COORD_W + FRAC_W;
  localparam int unsigned CZ_W     = CENTER_W + 1 + COORD_W;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_FOCAL_SCALE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y    = 2'd2;

  localparam logic [FOCAL_W-1:0]  FOCAL_RESET  = 31'd26214400;
  localparam logic [CENTER_W-1:0] CENTER_RESET = 10'd400;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PROJ,
    ST_DEPTH,
    ST_RESULT
  } ppdt_state_t;

  typedef struct packed {
    logic done;
    logic ok;
  } proj_stat_t;

  typedef struct packed {
    logic clr_start;
    logic req;
  } dep_ctrl_t;

  typedef struct packed {
    logic valid;
    logic plotted;
  } dep_resp_t;

endpackage

`default_nettype wire

[hw/rtl/point_project_depth_test.sv]
// top level: projects eye space points and depth tests them against the store
//
// input channel: in_valid / in_stall carry one word of mode, point_x, point_y,
// point_z (signed q16.16). mode 1 clears the whole depth store.
// result channel: out_valid / out_stall carry one word per input word:
// out_plotted and the pixel position (zero when not plotted).
// configuration: cfg_wr_en writes cfg_data into register cfg_index (0 focal_scale,
// 1 center_x, 2 center_y); the user must write only while the block is idle,
// which the block itself does not enforce.
// one word is in flight at a time. a point is projected with an iterative
// divide that retires one quotient bit per cycle over QW =
// clog2(max(SCREEN_WIDTH, SCREEN_HEIGHT)) bits; a point that lands on the
// screen with nonzero depth is then depth tested by a read, compare and
// write back of its store entry before its word appears on out_valid.
// a clear word sweeps all SCREEN_WIDTH * SCREEN_HEIGHT store entries (640000
// at 800 x 800), one entry per cycle, then returns its word.
// reset: synchronous active low rst_n restores the register defaults and
// starts the same sweep; in_stall stays high until it ends.
// a finished word waits in the output register while out_stall is high; the
// next input word is still taken and held back only when it is done.
`default_nettype none

module point_project_depth_test
  import ppdt_pkg::*;
#(
  parameter int unsigned SCREEN_WIDTH  = 800,
  parameter int unsigned SCREEN_HEIGHT = 800
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  // configuration write port
  input  wire logic                       cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [FOCAL_W-1:0]         cfg_data,
  // input channel
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic                       in_mode,
  input  wire logic signed [COORD_W-1:0]  in_point_x,
  input  wire logic signed [COORD_W-1:0]  in_point_y,
  input  wire logic signed [COORD_W-1:0]  in_point_z,
  // result channel
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic                            out_plotted,
  output logic [PIX_W-1:0]                out_pixel_x,
  output logic [PIX_W-1:0]                out_pixel_y
);

  localparam int unsigned QW = $clog2((SCREEN_WIDTH > SCREEN_HEIGHT) ?
                                      SCREEN_WIDTH : SCREEN_HEIGHT);

  // configuration registers
  logic [FOCAL_W-1:0]  focal_r;
  logic [CENTER_W-1:0] center_x_r, center_y_r;

  // sequencer
  ppdt_state_t state_r, state_nxt;
  logic        clr_res_r;

  // pending result and output register
  logic              res_plot_r;
  logic [PIX_W-1:0]  res_px_r, res_py_r;
  logic              out_valid_r, out_plotted_r;
  logic [PIX_W-1:0]  out_pixel_x_r, out_pixel_y_r;
  logic signed [COORD_W-1:0] pz_r;

  logic       in_accept, out_free, out_load, proj_start;
  proj_stat_t pstat;
  dep_ctrl_t  dctrl;
  dep_resp_t  dresp;
  logic       clr_busy;
  logic [QW-1:0] col, row;

  // register writes; out of range indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      focal_r    <= FOCAL_RESET;
      center_x_r <= CENTER_RESET;
      center_y_r <= CENTER_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_FOCAL_SCALE: focal_r    <= cfg_data;
        CFG_CENTER_X:    center_x_r <= cfg_data[CENTER_W-1:0];
        CFG_CENTER_Y:    center_y_r <= cfg_data[CENTER_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (!clr_busy) begin
          state_nxt = clr_res_r ? ST_RESULT : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_accept) begin
          state_nxt = in_mode ? ST_CLEAR : ST_PROJ;
        end
      end
      ST_PROJ: begin
        if (pstat.done) begin
          state_nxt = pstat.ok ? ST_DEPTH : ST_RESULT;
        end
      end
      ST_DEPTH: begin
        if (dresp.valid) begin
          state_nxt = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall        = (state_r != ST_IDLE);
    proj_start      = (state_r == ST_IDLE) && in_valid && !in_mode;
    dctrl.clr_start = (state_r == ST_IDLE) && in_valid && in_mode;
    dctrl.req       = (state_r == ST_PROJ) && pstat.done && pstat.ok;
    out_load        = (state_r == ST_RESULT) && out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_res_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (dctrl.clr_start) begin
        clr_res_r <= 1'b1;
      end else if ((state_r == ST_CLEAR) && !clr_busy) begin
        clr_res_r <= 1'b0;
      end
    end
  end

  // result defaults to not plotted, filled in by the depth test
  always_ff @(posedge clk) begin
    if (in_accept) begin
      res_plot_r <= 1'b0;
      res_px_r   <= '0;
      res_py_r   <= '0;
      pz_r       <= in_point_z;
    end else if ((state_r == ST_DEPTH) && dresp.valid) begin
      res_plot_r <= dresp.plotted;
      res_px_r   <= dresp.plotted ? PIX_W'(col) : '0;
      res_py_r   <= dresp.plotted ? PIX_W'(row) : '0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_plotted_r <= res_plot_r;
      out_pixel_x_r <= res_px_r;
      out_pixel_y_r <= res_py_r;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_plotted = out_plotted_r;
  assign out_pixel_x = out_pixel_x_r;
  assign out_pixel_y = out_pixel_y_r;

  ppdt_proj #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_proj (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (proj_start),
    .focal    (focal_r),
    .center_x (center_x_r),
    .center_y (center_y_r),
    .point_x  (in_point_x),
    .point_y  (in_point_y),
    .point_z  (in_point_z),
    .stat     (pstat),
    .col      (col),
    .row      (row)
  );

  ppdt_depth #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_depth (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (dctrl),
    .col      (col),
    .row      (row),
    .depth    (pz_r),
    .clr_busy (clr_busy),
    .resp     (dresp)
  );

endmodule

`default_nettype wire

[hw/rtl/ppdt_proj.sv]
// projection unit: products, numerator build and iterative restoring divide
`default_nettype none

module ppdt_proj
  import ppdt_pkg::*;
#(
  parameter int unsigned SCREEN_WIDTH  = 800,
  parameter int unsigned SCREEN_HEIGHT = 800,
  localparam int unsigned QW = $clog2((SCREEN_WIDTH > SCREEN_HEIGHT) ?
                                      SCREEN_WIDTH : SCREEN_HEIGHT),
  localparam int unsigned CW = $clog2(QW)
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [FOCAL_W-1:0]         focal,
  input  wire logic [CENTER_W-1:0]        center_x,
  input  wire logic [CENTER_W-1:0]        center_y,
  input  wire logic signed [COORD_W-1:0]  point_x,
  input  wire logic signed [COORD_W-1:0]  point_y,
  input  wire logic signed [COORD_W-1:0]  point_z,
  output proj_stat_t                      stat,
  output logic [QW-1:0]                   col,
  output logic [QW-1:0]                   row
);

  logic mul_v_r, sum_v_r, div_v_r, done_r;
  logic [CW-1:0] step_r;

  logic signed [NUM_W-1:0]   prod_x_r, prod_y_r;
  logic signed [CZ_W-1:0]    cz_x_r, cz_y_r;
  logic signed [COORD_W-1:0] z_r;
  logic [NUM_W-1:0] nmag_x_r, nmag_y_r;
  logic [DEN_W-1:0] dmag_r;
  logic neg_x_r, neg_y_r, zero_r, ovf_x_r, ovf_y_r;
  logic [NUM_W-1:0] rem_x_r, rem_y_r, dsh_r;
  logic [QW-1:0] q_x_r, q_y_r;

  logic [NUM_W-1:0] czx_ext, czy_ext, num_x, num_y, dmag_ext;
  logic [COORD_W-1:0] zmag;
  logic ge_x, ge_y, col_ok, row_ok;

  // numerator: focal*c + center*65536*z
  assign czx_ext  = {{(NUM_W-CZ_W){cz_x_r[CZ_W-1]}}, cz_x_r};
  assign czy_ext  = {{(NUM_W-CZ_W){cz_y_r[CZ_W-1]}}, cz_y_r};
  assign num_x    = prod_x_r + (czx_ext << FRAC_W);
  assign num_y    = prod_y_r + (czy_ext << FRAC_W);
  assign zmag     = z_r[COORD_W-1] ? (~z_r + COORD_W'(1)) : z_r;
  assign dmag_ext = NUM_W'(dmag_r);

  assign ge_x = rem_x_r >= dsh_r;
  assign ge_y = rem_y_r >= dsh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_v_r <= 1'b0;
      sum_v_r <= 1'b0;
      div_v_r <= 1'b0;
      done_r  <= 1'b0;
      step_r  <= '0;
    end else begin
      mul_v_r <= start;
      sum_v_r <= mul_v_r;
      done_r  <= div_v_r && (step_r == '0);
      if (sum_v_r) begin
        div_v_r <= 1'b1;
        step_r  <= CW'(QW - 1);
      end else if (div_v_r) begin
        if (step_r == '0) begin
          div_v_r <= 1'b0;
        end else begin
          step_r <= step_r - CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      prod_x_r <= $signed({1'b0, focal}) * point_x;
      prod_y_r <= $signed({1'b0, focal}) * point_y;
      cz_x_r   <= $signed({1'b0, center_x}) * point_z;
      cz_y_r   <= $signed({1'b0, center_y}) * point_z;
      z_r      <= point_z;
    end
    if (mul_v_r) begin
      nmag_x_r <= num_x[NUM_W-1] ? (~num_x + NUM_W'(1)) : num_x;
      nmag_y_r <= num_y[NUM_W-1] ? (~num_y + NUM_W'(1)) : num_y;
      neg_x_r  <= num_x[NUM_W-1] ^ z_r[COORD_W-1];
      neg_y_r  <= num_y[NUM_W-1] ^ z_r[COORD_W-1];
      dmag_r   <= {zmag, {FRAC_W{1'b0}}};
      zero_r   <= (z_r == '0);
    end
    if (sum_v_r) begin
      // quotient magnitude too large for any screen position
      ovf_x_r <= nmag_x_r >= (dmag_ext << QW);
      ovf_y_r <= nmag_y_r >= (dmag_ext << QW);
      rem_x_r <= nmag_x_r;
      rem_y_r <= nmag_y_r;
      dsh_r   <= dmag_ext << (QW - 1);
      q_x_r   <= '0;
      q_y_r   <= '0;
    end else if (div_v_r) begin
      rem_x_r <= ge_x ? (rem_x_r - dsh_r) : rem_x_r;
      rem_y_r <= ge_y ? (rem_y_r - dsh_r) : rem_y_r;
      q_x_r   <= {q_x_r[QW-2:0], ge_x};
      q_y_r   <= {q_y_r[QW-2:0], ge_y};
      dsh_r   <= dsh_r >> 1;
    end
  end

  // truncation toward zero: a negative quotient is on screen only as zero
  assign col_ok = !ovf_x_r && (!neg_x_r || (q_x_r == '0)) &&
                  ({1'b0, q_x_r} < (QW + 1)'(SCREEN_WIDTH));
  assign row_ok = !ovf_y_r && (!neg_y_r || (q_y_r == '0)) &&
                  ({1'b0, q_y_r} < (QW + 1)'(SCREEN_HEIGHT));

  assign stat = '{done: done_r, ok: (!zero_r && col_ok && row_ok)};
  assign col  = q_x_r;
  assign row  = q_y_r;

endmodule

`default_nettype wire

[hw/rtl/ppdt_depth.sv]
// depth store memory with clearing sweep and read, compare, write back
`default_nettype none

module ppdt_depth
  import ppdt_pkg::*;
#(
  parameter int unsigned SCREEN_WIDTH  = 800,
  parameter int unsigned SCREEN_HEIGHT = 800,
  localparam int unsigned QW = $clog2((SCREEN_WIDTH > SCREEN_HEIGHT) ?
                                      SCREEN_WIDTH : SCREEN_HEIGHT),
  localparam int unsigned N  = SCREEN_WIDTH * SCREEN_HEIGHT,
  localparam int unsigned AW = $clog2(N)
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire dep_ctrl_t                  ctrl,
  input  wire logic [QW-1:0]              col,
  input  wire logic [QW-1:0]              row,
  input  wire logic signed [DEPTH_W-1:0]  depth,
  output logic                            clr_busy,
  output dep_resp_t                       resp
);

  logic [DEPTH_W-1:0] mem [N];

  logic clr_busy_r, a_v_r, b_v_r;
  logic [AW-1:0] clr_cnt_r, addr_r;
  logic signed [DEPTH_W-1:0] z_r;
  logic [DEPTH_W-1:0] rdata_r;

  logic hit, we;
  logic [AW-1:0] waddr;
  logic [DEPTH_W-1:0] wdata;

  // empty entry or a farther point already stored
  assign hit = (rdata_r == '0) || ($signed(rdata_r) > z_r);

  assign we    = clr_busy_r || (b_v_r && hit);
  assign waddr = clr_busy_r ? clr_cnt_r : addr_r;
  assign wdata = clr_busy_r ? '0 : z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_cnt_r  <= '0;
      a_v_r      <= 1'b0;
      b_v_r      <= 1'b0;
    end else begin
      a_v_r <= ctrl.req;
      b_v_r <= a_v_r;
      if (ctrl.clr_start) begin
        clr_busy_r <= 1'b1;
        clr_cnt_r  <= '0;
      end else if (clr_busy_r) begin
        if (clr_cnt_r == AW'(N - 1)) begin
          clr_busy_r <= 1'b0;
        end else begin
          clr_cnt_r <= clr_cnt_r + AW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.req) begin
      addr_r <= AW'(AW'(col) * AW'(SCREEN_HEIGHT)) + AW'(row);
      z_r    <= depth;
    end
  end

  always_ff @(posedge clk) begin
    if (a_v_r) begin
      rdata_r <= mem[addr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  assign clr_busy = clr_busy_r;
  assign resp     = '{valid: b_v_r, plotted: hit};

endmodule

`default_nettype wire
